/* design/ecf_pkg.sv */
// Shared constants, types and helper functions for the easing curve factor unit.
package ecf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LOG_N     = 256;
  localparam int IO_W      = FRAC_BITS + 1;
  localparam int CURVE_W   = 4;
  localparam int LOG_IDX_W = $clog2(LOG_N + 1);
  localparam int CNT_W     = 3;
  localparam int NUM_STG   = 5;

  localparam logic [IO_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [IO_W-1:0] HALF = IO_W'(1) << (FRAC_BITS - 1);

  localparam longint unsigned Q30_ONE       = 64'd1 << 30;
  localparam longint unsigned E_MINUS_1_Q30 = 64'd1844991065;

  typedef enum logic [CURVE_W-1:0] {
    CRV_LINEAR    = 4'd0,
    CRV_QUAD_IN   = 4'd1,
    CRV_QUAD_OUT  = 4'd2,
    CRV_CUBIC_IN  = 4'd3,
    CRV_CUBIC_OUT = 4'd4,
    CRV_QUART_IN  = 4'd5,
    CRV_QUART_OUT = 4'd6,
    CRV_QUINT_IN  = 4'd7,
    CRV_QUINT_OUT = 4'd8,
    CRV_LOG       = 4'd9
  } curve_t;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_POW_IN,
    KIND_POW_OUT,
    KIND_LOG
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic [IO_W-1:0]             t_sat;
    logic [IO_W-1:0]             base;
    logic [IO_W-1:0]             pwr;
    logic [CNT_W-1:0]            cnt;
    logic [IO_W-1:0]             log_a;
    logic [IO_W-1:0]             log_d;
    logic [FRAC_BITS-1:0]        frac;
    logic [IO_W+FRAC_BITS-1:0]   log_prod;
    logic [IO_W-1:0]             log_res;
  } item_t;

  typedef logic [IO_W-1:0] log_rom_t [0:LOG_N];

  // Fixed-point product, rounded half up to FRAC_BITS fraction bits.
  function automatic logic [IO_W-1:0] qmul(input logic [IO_W-1:0] a,
                                           input logic [IO_W-1:0] b);
    logic [2*IO_W-1:0] prod;
    prod = (2*IO_W)'(a) * (2*IO_W)'(b) + (2*IO_W)'(HALF);
    return prod[FRAC_BITS +: IO_W];
  endfunction

  // Unsigned quotient by shift and subtract; used only while building the table.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((n >> b) & 64'd1);
      if (rem >= d) begin
        rem = rem - d;
        q   = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // Log table: point i is ln(1 + (i/N)(e-1)) via 2*atanh((x-1)/(x+1)) in Q.30.
  function automatic log_rom_t build_log_rom();
    log_rom_t          rom;
    longint unsigned   x;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   y;
    longint unsigned   y2;
    longint unsigned   term;
    longint unsigned   sum;
    longint unsigned   k;
    longint unsigned   r;
    for (int i = 0; i <= LOG_N; i++) begin
      if (i == LOG_N) begin
        rom[i] = ONE;
      end else begin
        x    = Q30_ONE + (E_MINUS_1_Q30 * longint'(i) + longint'(LOG_N / 2)) / LOG_N;
        num  = x - Q30_ONE;
        den  = x + Q30_ONE;
        y    = udiv64(num << 30, den);
        y2   = (y * y) >> 30;
        term = y;
        sum  = 0;
        k    = 1;
        while (term != 0 && k < 200) begin
          sum  = sum + udiv64(term, k);
          term = (term * y2) >> 30;
          k    = k + 2;
        end
        sum = sum * 2;
        r   = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (r > longint'(ONE)) begin
          r = longint'(ONE);
        end
        rom[i] = IO_W'(r);
      end
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

/* design/ecf_in_if.sv */
// Input channel: progress value and curve code with valid/ready handshake.
interface ecf_in_if;
  import ecf_pkg::*;

  logic               valid;
  logic               ready;
  logic [IO_W-1:0]    t;
  logic [CURVE_W-1:0] curve;

  modport source (output valid, output t, output curve, input ready);
  modport sink   (input valid, input t, input curve, output ready);
endinterface

/* design/ecf_out_if.sv */
// Result channel: eased factor with valid/ready handshake.
interface ecf_out_if;
  import ecf_pkg::*;

  logic            valid;
  logic            ready;
  logic [IO_W-1:0] factor;

  modport source (output valid, output factor, input ready);
  modport sink   (input valid, input factor, output ready);
endinterface

/* design/easing_curve_factor_unit.sv */
// Pipelined easing curve unit: power ease-in/out and logarithmic curves.
//
//   channel  | dir | word contents              | handshake
//   ---------+-----+----------------------------+-------------------------
//   in_ch    | in  | t (Q.16, 17b), curve (4b)  | valid/ready, accept on both
//   out_ch   | out | factor (Q.16, 17b)         | valid/ready, accept on both
//
// One word enters per cycle unless the output stalls; a word passes five datapath
// stages and then the output register. Stages 2..5 each hold one 17x17 power
// multiplier, which sets the stage count: a quintic needs four chained products.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// A stalled output holds its word; each stage keeps loading while the stage
// after it is empty or moving, so bubbles close up under backpressure.
module easing_curve_factor_unit (
  input  logic clk,
  input  logic rst_n,
  ecf_in_if.sink   in_ch,
  ecf_out_if.source out_ch
);
  import ecf_pkg::*;

  // Stage registers; stage 1 is loaded from the input word.
  item_t           stg_r   [1:NUM_STG];
  item_t           stg_nxt [1:NUM_STG];
  logic            vld_r   [1:NUM_STG];
  logic            adv     [1:NUM_STG];
  logic            adv_out;

  logic            out_vld_r;
  logic [IO_W-1:0] out_factor_r;
  logic [IO_W-1:0] out_factor_nxt;

  // Input decode signals.
  logic [IO_W-1:0]           t_sat;
  logic [IO_W+LOG_IDX_W-1:0] scaled;
  logic [LOG_IDX_W-1:0]      idx_lo;
  logic [LOG_IDX_W-1:0]      idx_hi;
  logic [IO_W-1:0]           rom_a;
  logic [IO_W-1:0]           rom_b;
  logic [CURVE_W:0]          curve_inc;
  logic [IO_W:0]             log_sum;

  // One power step: multiply by the base while multiplications remain.
  function automatic item_t pow_step(input item_t it);
    item_t o;
    o = it;
    if (it.cnt != '0) begin
      o.pwr = qmul(it.pwr, it.base);
      o.cnt = it.cnt - 1'b1;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or the next one advances.
  // ---------------------------------------------------------------------
  always_comb begin
    adv_out      = !out_vld_r || out_ch.ready;
    adv[NUM_STG] = !vld_r[NUM_STG] || adv_out;
    for (int k = NUM_STG - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[1];

  always_comb begin
    // -------------------------------------------------------------------
    // Stage 1 input: saturate t, classify the curve, look up the log table.
    // -------------------------------------------------------------------
    t_sat  = (in_ch.t > ONE) ? ONE : in_ch.t;
    scaled = (IO_W+LOG_IDX_W)'(t_sat) * (IO_W+LOG_IDX_W)'(LOG_N);
    idx_lo = scaled[FRAC_BITS +: LOG_IDX_W];
    // at t = 1.0 the upper point is the last one itself
    idx_hi = (idx_lo == LOG_IDX_W'(LOG_N)) ? idx_lo : idx_lo + 1'b1;
    rom_a  = LOG_ROM[idx_lo];
    rom_b  = LOG_ROM[idx_hi];

    curve_inc = {1'b0, in_ch.curve} + (CURVE_W+1)'(1);

    stg_nxt[1]          = '0;
    stg_nxt[1].t_sat    = t_sat;
    stg_nxt[1].log_a    = rom_a;
    stg_nxt[1].log_d    = (rom_b < rom_a) ? '0 : rom_b - rom_a;
    stg_nxt[1].frac     = scaled[FRAC_BITS-1:0];

    unique case (in_ch.curve)
      CRV_QUAD_IN, CRV_CUBIC_IN, CRV_QUART_IN, CRV_QUINT_IN: begin
        stg_nxt[1].kind = KIND_POW_IN;
      end
      CRV_QUAD_OUT, CRV_CUBIC_OUT, CRV_QUART_OUT, CRV_QUINT_OUT: begin
        stg_nxt[1].kind = KIND_POW_OUT;
      end
      CRV_LOG: begin
        stg_nxt[1].kind = KIND_LOG;
      end
      default: begin
        // linear and undefined codes pass t through
        stg_nxt[1].kind = KIND_PASS;
      end
    endcase

    // exponent n = (curve+3)/2, so n-1 multiplications remain
    if (stg_nxt[1].kind == KIND_POW_IN || stg_nxt[1].kind == KIND_POW_OUT) begin
      stg_nxt[1].cnt = curve_inc[CNT_W:1];
    end
    stg_nxt[1].base = (stg_nxt[1].kind == KIND_POW_OUT) ? ONE - t_sat : t_sat;
    stg_nxt[1].pwr  = stg_nxt[1].base;

    // -------------------------------------------------------------------
    // Stages 2..5: one power multiplication each; log interpolation rides along.
    // -------------------------------------------------------------------
    for (int k = 2; k <= NUM_STG; k++) begin
      stg_nxt[k] = pow_step(stg_r[k-1]);
    end

    // stage 2: slope times fraction
    stg_nxt[2].log_prod = (IO_W+FRAC_BITS)'(stg_r[1].log_d) *
                          (IO_W+FRAC_BITS)'(stg_r[1].frac);

    // stage 3: round and add to the lower point, clamp at one
    log_sum = {1'b0, stg_r[2].log_a} +
              (IO_W+1)'((stg_r[2].log_prod + (IO_W+FRAC_BITS)'(HALF)) >> FRAC_BITS);
    stg_nxt[3].log_res = (log_sum > (IO_W+1)'(ONE)) ? ONE : log_sum[IO_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Output select.
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (stg_r[NUM_STG].kind)
      KIND_POW_IN:  out_factor_nxt = stg_r[NUM_STG].pwr;
      KIND_POW_OUT: out_factor_nxt = ONE - stg_r[NUM_STG].pwr;
      KIND_LOG:     out_factor_nxt = stg_r[NUM_STG].log_res;
      default:      out_factor_nxt = stg_r[NUM_STG].t_sat;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers: advance valid bits with the data, hold on stall.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NUM_STG; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else begin
      if (adv[1]) begin
        vld_r[1] <= in_ch.valid;
      end
      for (int k = 2; k <= NUM_STG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (adv_out) begin
        out_vld_r <= vld_r[NUM_STG];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NUM_STG; k++) begin
      if (adv[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
    if (adv_out) begin
      out_factor_r <= out_factor_nxt;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.factor = out_factor_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // all power multiplications finish before the select stage
  a_pow_done: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NUM_STG] |-> stg_r[NUM_STG].cnt == '0)
    else $error("power count not exhausted at last stage");

  // interpolated log never exceeds one
  a_log_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && stg_r[3].kind == KIND_LOG) |-> stg_r[3].log_res <= ONE)
    else $error("log interpolation above one");

  // an empty output register means the whole chain can take a word
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty output");

  // a shown word never exceeds one
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.factor <= ONE)
    else $error("factor above one");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the easing curve factor unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ecf_pkg::*;

  // Pipeline depth from input accept to output word.
  localparam int LATENCY     = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_CODES   = 1 << CURVE_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ecf_in_if  in_bus ();
  ecf_out_if out_bus ();

  easing_curve_factor_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #5 clk = ~clk;

  // Factors still owed by the block, oldest first.
  logic [IO_W-1:0] pending_factors [$];
  logic [IO_W-1:0] ln_table [0:LOG_N];
  logic [IO_W-1:0] want_factor;

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  hold_req       = 0;   // receiver hold-off request, picked up at the next falling edge
  bit  idling_on      = 1'b1;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Log table point: ln(1 + (idx/N)(e-1)) as 2*atanh((x-1)/(x+1)), series in Q.30.
  function automatic logic [IO_W-1:0] ln_point(input int idx);
    longint unsigned x;
    longint unsigned num;
    longint unsigned den;
    longint unsigned y;
    longint unsigned y2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned k;
    longint unsigned r;
    if (idx >= LOG_N) begin
      return ONE;
    end
    x    = Q30_ONE + (E_MINUS_1_Q30 * longint'(idx) + longint'(LOG_N / 2)) / LOG_N;
    num  = x - Q30_ONE;
    den  = x + Q30_ONE;
    y    = (num << 30) / den;
    y2   = (y * y) >> 30;
    term = y;
    acc  = 0;
    k    = 1;
    while (term != 0 && k < 200) begin
      acc  = acc + term / k;
      term = (term * y2) >> 30;
      k    = k + 2;
    end
    acc = acc * 2;
    r   = (acc + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (r > 64'(ONE)) begin
      r = 64'(ONE);
    end
    return IO_W'(r);
  endfunction

  // Product of two Q.FRAC_BITS values, rounded half up.
  function automatic longint unsigned fx_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b + 64'(HALF)) >> FRAC_BITS;
  endfunction

  function automatic longint unsigned fx_pow(input longint unsigned base, input int n);
    longint unsigned p;
    p = base;
    for (int k = 1; k < n; k++) begin
      p = fx_mul(p, base);
    end
    return p;
  endfunction

  function automatic longint unsigned ln_interp(input longint unsigned t);
    longint unsigned s;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    s    = t * LOG_N;
    idx  = s >> FRAC_BITS;
    frac = s & (64'(ONE) - 1);
    if (idx >= LOG_N) begin
      return 64'(ln_table[LOG_N]);
    end
    a = 64'(ln_table[idx]);
    b = 64'(ln_table[idx + 1]);
    if (b < a) begin
      b = a;
    end
    r = a + (((b - a) * frac + 64'(HALF)) >> FRAC_BITS);
    if (r > 64'(ONE)) begin
      r = 64'(ONE);
    end
    return r;
  endfunction

  function automatic logic [IO_W-1:0] eased_factor(input logic [IO_W-1:0] t_raw,
                                                   input logic [CURVE_W-1:0] crv);
    longint unsigned t;
    longint unsigned r;
    int              n;
    // Saturate progress above one before any curve.
    t = (t_raw > ONE) ? 64'(ONE) : 64'(t_raw);
    case (crv)
      CRV_QUAD_IN, CRV_QUAD_OUT, CRV_CUBIC_IN, CRV_CUBIC_OUT,
      CRV_QUART_IN, CRV_QUART_OUT, CRV_QUINT_IN, CRV_QUINT_OUT: begin
        n = (int'(crv) + 3) / 2;
        if (crv[0]) begin
          r = fx_pow(t, n);
        end else begin
          r = 64'(ONE) - fx_pow(64'(ONE) - t, n);
        end
      end
      CRV_LOG: begin
        r = ln_interp(t);
      end
      default: begin
        // Linear and every undefined code pass the saturated progress through.
        r = t;
      end
    endcase
    return IO_W'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then log its predicted factor.
  // Enter and leave at a falling edge.
  task automatic send_word(input logic [IO_W-1:0] t_val, input logic [CURVE_W-1:0] crv);
    while (idling_on && $urandom_range(99) < 31) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.t     <= t_val;
    in_bus.curve <= crv;
    @(posedge clk);
    while (!in_bus.ready) begin
      @(posedge clk);
    end
    pending_factors.push_back(eased_factor(t_val, crv));
    @(negedge clk);
  endtask

  // Progress values weighted toward the interesting corners.
  function automatic logic [IO_W-1:0] rand_progress();
    case ($urandom_range(9))
      0:       return IO_W'($urandom_range(15));
      1:       return IO_W'($urandom_range(int'(ONE), int'(ONE) - 16));
      2:       return IO_W'($urandom_range((1 << IO_W) - 1, int'(ONE) + 1));
      3:       return ONE;
      default: return IO_W'($urandom_range(int'(ONE)));
    endcase
  endfunction

  function automatic logic [CURVE_W-1:0] rand_curve();
    if ($urandom_range(99) < 85) begin
      return CURVE_W'($urandom_range(int'(CRV_LOG)));
    end
    return CURVE_W'($urandom_range(NUM_CODES - 1, int'(CRV_LOG) + 1));
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(rand_progress(), rand_curve());
    end
  endtask

  // Drop valid and hold until every owed factor has come back.
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    while (pending_factors.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every curve code once, plus the corners of t for the curves that bend most.
  task automatic test_directed();
    for (int c = 0; c < NUM_CODES; c++) begin
      send_word(IO_W'((c * 4099 + 777) % (int'(ONE) + 1)), CURVE_W'(c));
    end
    send_word('0, CRV_QUINT_OUT);
    send_word('0, CRV_LOG);
    send_word(IO_W'(1), CRV_QUAD_IN);           // product rounds to zero
    send_word(HALF, CRV_QUINT_IN);
    send_word(ONE - 1, CRV_LOG);                // last interpolation interval
    send_word(ONE - 1, CRV_CUBIC_OUT);
    send_word(ONE, CRV_LOG);                    // top table point
    send_word(ONE + 1, CRV_LINEAR);             // saturate just above one
    send_word('1, CRV_QUAD_IN);                 // saturate from all ones
    send_word('1, CRV_LOG);
    send_word('1, CURVE_W'(NUM_CODES - 1));     // undefined code, saturated t
  endtask

  task automatic test_random_mixed();
    send_random(1150);
  endtask

  // Stall the receiver for a long stretch while the sender keeps pushing,
  // so the pipeline fills and backs up into the input.
  task automatic test_backpressure();
    // drop the last accepted word so it is not taken again
    in_bus.valid <= 1'b0;
    @(posedge clk);
    hold_req = 300;
    @(negedge clk);
    idling_on = 1'b0;
    send_random(60);
    idling_on = 1'b1;
  endtask

  // Long stretch with no idling on either side.
  task automatic test_full_rate();
    idling_on = 1'b0;
    send_random(300);
    idling_on = 1'b1;
  endtask

  // Sender pauses until the block has fully drained, then resumes.
  task automatic test_pause_drain();
    send_random(40);
    wait_for_results();
    repeat (LATENCY) @(negedge clk);
    send_random(40);
  endtask

  task automatic test_random_tail();
    send_random(200);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, with a counted hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(idling_on && $urandom_range(99) < 31);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted word with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_factors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] unexpected factor word 0x%05h", $realtime, out_bus.factor);
        end
      end else begin
        want_factor = pending_factors.pop_front();
        if (out_bus.factor !== want_factor) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] factor mismatch: expected 0x%05h actual 0x%05h",
                     $realtime, want_factor, out_bus.factor);
          end
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_bus.valid = 1'b0;
    in_bus.t     = '0;
    in_bus.curve = '0;
    for (int i = 0; i <= LOG_N; i++) begin
      ln_table[i] = ln_point(i);
    end

    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_mixed();
    test_backpressure();
    test_full_rate();
    test_pause_drain();
    test_random_tail();

    // Drain, then give stray words time to show up.
    wait_for_results();
    repeat (LATENCY + 10) @(negedge clk);
    if (pending_factors.size() != 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0d factor words never arrived", pending_factors.size());
      end
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ecf_pkg.sv
design/ecf_in_if.sv
design/ecf_out_if.sv
design/easing_curve_factor_unit.sv
dv/testbench.sv
